// File: rtl/esct_pkg.sv
// Package for the extended step compare timer.
// Mode codes, register indexes, widths and the step compare placement function.
// No dependencies.
package esct_pkg;

	localparam int CntW   = 16;
	localparam int DelayW = 32;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;

	typedef enum logic [1:0] {
		MODE_CYCLE = 2'd0,
		MODE_SET   = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_INIT  = 2'd3
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TICK_PERIOD  = 2'd0,
		REG_SHORT_ENABLE = 2'd1,
		REG_SHORT_MARGIN = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	localparam logic [CntW-1:0]   TickPeriodReset  = 16'd16000;
	localparam logic [CntW-1:0]   ShortMarginReset = 16'd200;
	localparam logic [DelayW-1:0] WrapSpan         = 32'd65536;
	localparam logic [DelayW-1:0] NearSpan         = 32'd75536;
	localparam logic [CntW-1:0]   PullBack         = 16'd10000;

	typedef struct packed {
		logic            advance;
		mode_t           mode;
		logic            short_req;
	} step_cmd_t;

	typedef struct packed {
		logic [CntW-1:0]   cmp;
		logic [DelayW-1:0] rem;
	} place_t;

	// Compare placement for a fresh remainder measured from base.
	function automatic place_t place_step(input logic [CntW-1:0] base,
	                                      input logic [DelayW-1:0] rem);
		place_t p;
		p.cmp = base;
		p.rem = rem;
		if (rem < WrapSpan) begin
			p.cmp = base + rem[CntW-1:0];
		end else if (rem < NearSpan) begin
			p.cmp = base - PullBack;
			p.rem = rem + {16'd0, PullBack};
		end
		return p;
	endfunction

endpackage

// File: rtl/esct_step.sv
// Step compare channel: compare, 32-bit remainder, wrap counting and short check.
// Depends on esct_pkg.
module esct_step (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  esct_pkg::step_cmd_t                   cmd,
	input  logic signed [esct_pkg::DelayW-1:0]    delay,
	input  logic        [esct_pkg::CntW-1:0]      count,
	input  logic        [esct_pkg::CntW-1:0]      count_next,
	input  logic                                  short_check_enable,
	input  logic        [esct_pkg::CntW-1:0]      short_margin,
	output logic                                  fire,
	output logic                                  too_short,
	output logic                                  armed
);
	import esct_pkg::*;

	logic [CntW-1:0]   cmp_q, cmp_n;
	logic [DelayW-1:0] rem_q, rem_n;
	logic              en_q, en_n;
	logic [DelayW-1:0] rem_wrap;
	logic [CntW-1:0]   elapsed;
	logic [CntW:0]     limit;
	logic              short_hit;
	place_t            pl_match, pl_set;

	assign rem_wrap  = rem_q - WrapSpan;
	assign pl_match  = place_step(cmp_q, rem_wrap);
	assign pl_set    = place_step(cmp_q, delay);
	assign elapsed   = count - cmp_q;
	assign limit     = {1'b0, elapsed} + {1'b0, short_margin};
	assign short_hit = short_check_enable && cmd.short_req &&
	                   ($signed({16'd0, limit}) > $signed({delay[DelayW-1], delay}));

	always_comb begin
		cmp_n     = cmp_q;
		rem_n     = rem_q;
		en_n      = en_q;
		fire      = 1'b0;
		too_short = 1'b0;
		unique case (cmd.mode)
			MODE_CYCLE: begin
				if (en_q && count_next == cmp_q) begin
					if (rem_q[DelayW-1:CntW] == '0) begin
						fire = 1'b1;
						en_n = 1'b0;
					end else begin
						cmp_n = pl_match.cmp;
						rem_n = pl_match.rem;
					end
				end
			end
			MODE_SET: begin
				rem_n = delay;
				if (short_hit) begin
					too_short = 1'b1;
				end else begin
					cmp_n = pl_set.cmp;
					rem_n = pl_set.rem;
					en_n  = 1'b1;
				end
			end
			MODE_STOP, MODE_INIT: begin
				en_n = 1'b0;
			end
			default: begin
				en_n = en_q;
			end
		endcase
	end

	assign armed = en_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_q <= '0;
			rem_q <= '0;
			en_q  <= 1'b0;
		end else if (cmd.advance) begin
			cmp_q <= cmp_n;
			rem_q <= rem_n;
			en_q  <= en_n;
		end
	end

endmodule

// File: rtl/extended_step_compare_timer_top.sv
// Top level of the extended step compare timer: input register, counter, tick
// channel, configuration registers and result register. Depends on esct_pkg, esct_step.
//
// Each accepted item is one timer event (count, set, stop, init); one item is taken
// every clock while the result side is not stalled, and its result passes from the input
// register through one pass of compare logic into the result register. Back-pressure on
// the result side holds the input register, and ready drops only when both are full and
// result_ready is low.
module extended_step_compare_timer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [1:0]                         mode,
	input  logic signed [esct_pkg::DelayW-1:0] delay,
	input  logic                               short_req,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic                               step_fired,
	output logic                               tick_fired,
	output logic                               too_short,
	output logic                               step_armed,
	input  logic                               cfg_we,
	input  logic [esct_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [esct_pkg::CfgDataW-1:0]      cfg_data
);
	import esct_pkg::*;

	logic              s1_valid_q;
	mode_t             mode_s1;
	logic [DelayW-1:0] delay_s1;
	logic              check_s1;
	logic              advance;

	logic [CntW-1:0]   tick_period_q;
	logic              short_en_q;
	logic [CntW-1:0]   short_margin_q;

	logic [CntW-1:0]   count_q, count_n;
	logic [CntW-1:0]   tick_cmp_q, tick_cmp_n;
	logic              tick_en_q, tick_en_n;
	logic              tick_hit;

	step_cmd_t         step_cmd;
	logic              step_fire, step_short, step_arm;

	logic              out_valid_q;
	logic              step_fired_q, tick_fired_q, too_short_q, step_armed_q;

	assign advance    = s1_valid_q && (!out_valid_q || result_ready);
	assign item_ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_ready) begin
			s1_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			mode_s1  <= mode_t'(mode);
			delay_s1 <= delay;
			check_s1 <= short_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q  <= TickPeriodReset;
			short_en_q     <= 1'b0;
			short_margin_q <= ShortMarginReset;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TICK_PERIOD:  tick_period_q  <= cfg_data;
				REG_SHORT_ENABLE: short_en_q     <= cfg_data[0];
				REG_SHORT_MARGIN: short_margin_q <= cfg_data;
				default:          short_en_q     <= short_en_q;
			endcase
		end
	end

	assign count_n  = count_q + 16'd1;
	assign tick_hit = (mode_s1 == MODE_CYCLE) && tick_en_q && (count_n == tick_cmp_q);

	always_comb begin
		tick_cmp_n = tick_cmp_q;
		tick_en_n  = tick_en_q;
		unique case (mode_s1)
			MODE_CYCLE: begin
				if (tick_hit) begin
					tick_cmp_n = tick_cmp_q + tick_period_q;
				end
			end
			MODE_STOP: tick_en_n = 1'b0;
			MODE_INIT: begin
				tick_cmp_n = tick_period_q;
				tick_en_n  = 1'b1;
			end
			default: tick_en_n = tick_en_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			tick_cmp_q <= TickPeriodReset;
			tick_en_q  <= 1'b1;
		end else if (advance) begin
			if (mode_s1 == MODE_CYCLE) begin
				count_q <= count_n;
			end
			tick_cmp_q <= tick_cmp_n;
			tick_en_q  <= tick_en_n;
		end
	end

	assign step_cmd.advance   = advance;
	assign step_cmd.mode      = mode_s1;
	assign step_cmd.short_req = check_s1;

	esct_step u_step (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (step_cmd),
		.delay              (delay_s1),
		.count              (count_q),
		.count_next         (count_n),
		.short_check_enable (short_en_q),
		.short_margin       (short_margin_q),
		.fire               (step_fire),
		.too_short          (step_short),
		.armed              (step_arm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			step_fired_q <= step_fire;
			tick_fired_q <= tick_hit;
			too_short_q  <= step_short;
			step_armed_q <= step_arm;
		end
	end

	assign result_valid = out_valid_q;
	assign step_fired   = step_fired_q;
	assign tick_fired   = tick_fired_q;
	assign too_short    = too_short_q;
	assign step_armed   = step_armed_q;

`ifndef ASSERT_OFF
	a_short_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && too_short_q |-> !step_fired_q && !tick_fired_q)
		else $error("too_short together with a fire");

	a_fire_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && step_fired_q |-> !step_armed_q)
		else $error("step fired but still armed");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(delay_s1))
		else $error("input register lost a held item");

	a_count_only_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && mode_s1 == MODE_CYCLE) |=> $stable(count_q))
		else $error("counter moved without a cycle item");
`endif

endmodule
